// ----- hdl/brd_pkg.sv -----
// ---------------------------------------------------------------------------
// brd_pkg: shared types and constants of the binned RMS decimator
// Widths, action codes, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package brd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int MAX_BIN      = 4096;

  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int SIB_W     = $clog2(MAX_BIN);
  localparam int NCH_REG_W = 5;
  localparam int BIN_REG_W = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 13;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 8;
  localparam int CAL_W     = 40;
  localparam int CNT_W     = 24;
  localparam int MEAN_W    = 25;
  localparam int DIFF_W    = MEAN_W + 1;
  localparam int MAG_W     = MEAN_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SQ_W      = 62;
  localparam int DIV_W     = CNT_W;
  localparam int DCNT_W    = $clog2(SQ_W);
  localparam int RMS_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE     = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_CAL     = 2'd0,
    ACT_MEAS    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CAL,
    ST_FSTART,
    ST_FDIV,
    ST_FWRITE,
    ST_FDONE,
    ST_MULT,
    ST_ACC,
    ST_BSTART,
    ST_BDIV,
    ST_SQRT_START,
    ST_SQRT,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic cal_add;
    logic div_start;
    logic div_bin;
    logic mean_write;
    logic freeze_done;
    logic mult;
    logic acc;
    logic sqrt_start;
    logic emit;
    logic advance;
  } brd_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       frozen;
    logic       count_full;
    logic       frz_last;
    logic       bin_end;
    logic       div_busy;
    logic       sqrt_busy;
    logic       out_free;
  } brd_status_t;

endpackage

// ----- hdl/brd_ifs.sv -----
// ---------------------------------------------------------------------------
// brd interfaces: sample, result and configuration channels
// Valid/ready channels; a transaction completes when both are high.
// ---------------------------------------------------------------------------
interface brd_sample_if;
  import brd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface brd_result_if;
  import brd_pkg::*;
  logic              valid;
  logic              ready;
  logic [RMS_W-1:0]  rms_value;
  logic [CH_W-1:0]   channel_index;
  modport source (output valid, rms_value, channel_index, input ready);
  modport sink   (input valid, rms_value, channel_index, output ready);
endinterface

interface brd_cfg_if;
  import brd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/binned_rms_decimator.sv -----
// ---------------------------------------------------------------------------
// binned_rms_decimator: windowed RMS with DC offset removal
// Calibrates per-channel means, then emits the RMS deviation of each
// channel over every bin of scans.
//
//   channel   role      transaction carries
//   samples   sink      action, sample
//   results   source    rms_value, channel_index
//   cfg       sink      index, data (num_channels, bin_size)
//
// One item at a time: a new item is taken only in the idle state. A bin
// end adds a pass through the 62-step shared divider, a pass through the
// 31-step square root unit and one emit step.
// The first measurement item first runs the divider once for each of the
// 16 channel slots, whatever the channel setting, to freeze the means.
// Synchronous reset clears the configuration, the channel state and the
// busy and valid flags. A stalled result holds the block in its emit step;
// results accepted earlier leave the register with no bubble.
// ---------------------------------------------------------------------------
module binned_rms_decimator (
  input  logic         clk,
  input  logic         rst,
  brd_sample_if.sink   samples,
  brd_result_if.source results,
  brd_cfg_if.sink      cfg
);
  import brd_pkg::*;

  brd_cmd_t    cmd;
  brd_status_t status;
  logic        in_ready;

  assign samples.ready = in_ready;

  brd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .action  (samples.action),
    .sample  (samples.sample),
    .cfg     (cfg),
    .results (results),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// ----- hdl/brd_ctrl.sv -----
// ---------------------------------------------------------------------------
// brd_ctrl: sequencer of the binned RMS decimator
// Steps each accepted item through calibration, freeze, accumulate, divide,
// square root and emit phases by issuing commands to the datapath.
// ---------------------------------------------------------------------------
module brd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  brd_pkg::brd_status_t status,
  output brd_pkg::brd_cmd_t    cmd
);
  import brd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.action)
          ACT_RESTART: begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
          ACT_CAL: begin
            state_next = (status.frozen || status.count_full) ? ST_IDLE : ST_CAL;
          end
          ACT_MEAS: begin
            state_next = status.frozen ? ST_MULT : ST_FSTART;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_CAL: begin
        cmd.cal_add = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_FSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_FDIV;
      end
      ST_FDIV: begin
        if (!status.div_busy) state_next = ST_FWRITE;
      end
      ST_FWRITE: begin
        cmd.mean_write = 1'b1;
        state_next     = status.frz_last ? ST_FDONE : ST_FSTART;
      end
      ST_FDONE: begin
        cmd.freeze_done = 1'b1;
        state_next      = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.bin_end ? ST_BSTART : ST_ADVANCE;
      end
      ST_BSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_bin   = 1'b1;
        state_next    = ST_BDIV;
      end
      ST_BDIV: begin
        if (!status.div_busy) state_next = ST_SQRT_START;
      end
      ST_SQRT_START: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_SQRT;
      end
      ST_SQRT: begin
        if (!status.sqrt_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/brd_dp.sv -----
// ---------------------------------------------------------------------------
// brd_dp: datapath of the binned RMS decimator
// Per-channel sums, frozen means and square sums, a shared restoring
// divider, a digit-by-digit square root and the output register.
// ---------------------------------------------------------------------------
module brd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    action,
  input  logic signed [brd_pkg::SAMPLE_W-1:0] sample,
  brd_cfg_if.sink                       cfg,
  brd_result_if.source                  results,
  input  brd_pkg::brd_cmd_t             cmd,
  output brd_pkg::brd_status_t          status
);
  import brd_pkg::*;

  // configuration
  logic [NCH_REG_W-1:0] reg_nch;
  logic [BIN_REG_W-1:0] reg_bin;
  logic [CH_W:0]        eff_nch;
  logic [BIN_REG_W-1:0] eff_bin;
  logic [CH_W-1:0]      last_ch;
  logic [SIB_W-1:0]     bin_last;

  // item and state
  logic [1:0]                 act_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [CAL_W-1:0]           calib_sum [MAX_CHANNELS];
  logic [MEAN_W-1:0]          channel_mean [MAX_CHANNELS];
  logic [SQ_W-1:0]            square_sum [MAX_CHANNELS];
  logic [CNT_W-1:0]           calib_scan_count;
  logic                       means_frozen;
  logic [SIB_W-1:0]           scan_in_bin;
  logic [CH_W-1:0]            pos;
  logic [CH_W-1:0]            fc;
  logic                       scan_end;
  logic                       bin_end;

  // arithmetic
  logic [CAL_W-1:0]     cal_raw;
  logic [CAL_W-1:0]     cal_mag;
  logic [MEAN_W-1:0]    quo_mean;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]     diff_mag;
  logic [PROD_W-1:0]    prod;

  // divider
  logic [SQ_W-1:0]   dvd;
  logic [SQ_W-1:0]   quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DCNT_W-1:0] dcnt;
  logic              div_busy;

  // square root
  logic [SQ_W-1:0] sq_v;
  logic [SQ_W-1:0] sq_res;
  logic [SQ_W-1:0] sq_bit;
  logic [SQ_W-1:0] sq_trial;
  logic            sqrt_busy;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (reg_nch == '0) begin
      eff_nch = (CH_W+1)'(1);
    end else if (reg_nch > NCH_REG_W'(MAX_CHANNELS)) begin
      eff_nch = (CH_W+1)'(MAX_CHANNELS);
    end else begin
      eff_nch = (CH_W+1)'(reg_nch);
    end
    if (reg_bin == '0) begin
      eff_bin = BIN_REG_W'(1);
    end else if (reg_bin > BIN_REG_W'(MAX_BIN)) begin
      eff_bin = BIN_REG_W'(MAX_BIN);
    end else begin
      eff_bin = reg_bin;
    end
  end

  assign last_ch  = CH_W'(eff_nch - (CH_W+1)'(1));
  assign bin_last = SIB_W'(eff_bin - BIN_REG_W'(1));
  assign scan_end = pos >= last_ch;
  assign bin_end  = scan_in_bin >= bin_last;

  assign cal_raw  = calib_sum[fc];
  assign cal_mag  = cal_raw[CAL_W-1] ? (~cal_raw + CAL_W'(1)) : cal_raw;
  assign quo_mean = (calib_scan_count == '0) ? '0 : quo[MEAN_W-1:0];

  assign diff = DIFF_W'($signed({smp_q, {FRAC_W{1'b0}}}))
              - DIFF_W'($signed(channel_mean[pos]));
  assign diff_mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign trial    = {rem, dvd[SQ_W-1]};
  assign sq_trial = sq_res + sq_bit;

  assign status.action     = act_q;
  assign status.frozen     = means_frozen;
  assign status.count_full = &calib_scan_count;
  assign status.frz_last   = fc == CH_W'(MAX_CHANNELS - 1);
  assign status.bin_end    = bin_end;
  assign status.div_busy   = div_busy;
  assign status.sqrt_busy  = sqrt_busy;
  assign status.out_free   = !results.valid || results.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_nch <= NCH_REG_W'(1);
      reg_bin <= BIN_REG_W'(10);
    end else if (cfg.valid) begin
      if (cfg.index == REG_NUM_CHANNELS) reg_nch <= cfg.data[NCH_REG_W-1:0];
      if (cfg.index == REG_BIN_SIZE)     reg_bin <= cfg.data[BIN_REG_W-1:0];
    end
  end

  // item latch and product register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q <= action;
      smp_q <= sample;
    end
    if (cmd.mult) prod <= diff_mag * diff_mag;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        calib_sum[i]    <= '0;
        channel_mean[i] <= '0;
        square_sum[i]   <= '0;
      end
      calib_scan_count <= '0;
      means_frozen     <= 1'b0;
      scan_in_bin      <= '0;
      pos              <= '0;
      fc               <= '0;
    end else begin
      if (cmd.cal_add) begin
        calib_sum[pos] <= calib_sum[pos] + CAL_W'(smp_q);
        if (scan_end) begin
          calib_scan_count <= calib_scan_count + CNT_W'(1);
          pos              <= '0;
        end else begin
          pos <= pos + CH_W'(1);
        end
      end
      if (cmd.mean_write) begin
        channel_mean[fc] <= cal_raw[CAL_W-1] ? (~quo_mean + MEAN_W'(1)) : quo_mean;
        fc               <= fc + CH_W'(1);
      end
      if (cmd.freeze_done) begin
        means_frozen <= 1'b1;
        pos          <= '0;
        scan_in_bin  <= '0;
        fc           <= '0;
      end
      if (cmd.acc) square_sum[pos] <= square_sum[pos] + SQ_W'(prod);
      if (cmd.emit) square_sum[pos] <= '0;
      if (cmd.advance) begin
        if (scan_end) begin
          pos         <= '0;
          scan_in_bin <= bin_end ? '0 : scan_in_bin + SIB_W'(1);
        end else begin
          pos <= pos + CH_W'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && dcnt == DCNT_W'(SQ_W - 1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= cmd.div_bin ? square_sum[pos] : SQ_W'({cal_mag, {FRAC_W{1'b0}}});
      dvs  <= cmd.div_bin ? DIV_W'(eff_bin) : calib_scan_count;
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
    end else if (div_busy) begin
      dvd  <= dvd << 1;
      dcnt <= dcnt + DCNT_W'(1);
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
        quo <= {quo[SQ_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[SQ_W-2:0], 1'b0};
      end
    end
  end

  // square root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy <= 1'b1;
    end else if (sqrt_busy && sq_bit[0]) begin
      sqrt_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= quo;
      sq_res <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 2);
    end else if (sqrt_busy) begin
      sq_bit <= sq_bit >> 2;
      if (sq_v >= sq_trial) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.rms_value     <= (sq_res > SQ_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}}
                                                               : sq_res[RMS_W-1:0];
      results.channel_index <= pos;
    end
  end

endmodule

// ----- tb/brd_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// brd_checker: result predictor and scoreboard of the binned RMS decimator
// Watches the sample, result and configuration channels, keeps its own copy
// of the calibration and bin state, and compares every result transaction
// with the oldest predicted one.
// ---------------------------------------------------------------------------
module brd_checker (
  input  logic  clk,
  input  logic  rst,
  brd_sample_if smp,
  brd_result_if res,
  brd_cfg_if    cfg,
  output int    errors,
  output int    pending
);
  import brd_pkg::*;

  typedef struct {
    logic [RMS_W-1:0] rms;
    logic [CH_W-1:0]  ch;
  } rms_result_t;

  rms_result_t rms_expected_q[$];

  logic [CAL_W-1:0]     cal_sum [MAX_CHANNELS];
  logic [CNT_W-1:0]     cal_scans;
  longint               mean_q8 [MAX_CHANNELS];
  bit                   frozen;
  logic [SQ_W-1:0]      dev_sq_sum [MAX_CHANNELS];
  int                   scan_in_bin;
  int                   chan_pos;
  logic [NCH_REG_W-1:0] nch_reg;
  logic [BIN_REG_W-1:0] bin_reg;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic clear_all();
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      cal_sum[c]    = '0;
      mean_q8[c]    = 0;
      dev_sq_sum[c] = '0;
    end
    cal_scans   = '0;
    frozen      = 0;
    scan_in_bin = 0;
    chan_pos    = 0;
  endtask

  task automatic freeze_means();
    logic [CAL_W-1:0] raw;
    logic [CAL_W-1:0] mag;
    longint unsigned  q;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      raw = cal_sum[c];
      mag = raw[CAL_W-1] ? -raw : raw;
      q = 0;
      if (cal_scans != 0) q = (longint'(mag) << FRAC_W) / longint'(cal_scans);
      mean_q8[c] = raw[CAL_W-1] ? -longint'(q) : longint'(q);
    end
    frozen      = 1;
    chan_pos    = 0;
    scan_in_bin = 0;
  endtask

  task automatic predict_sample(logic [1:0] act, logic signed [SAMPLE_W-1:0] s);
    int              nch;
    int              bin;
    int              pos;
    bit              scan_end;
    bit              bin_end;
    longint          d;
    longint unsigned m;
    longint unsigned r;
    rms_result_t     e;
    nch = (nch_reg == 0) ? 1 : (nch_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(nch_reg);
    bin = (bin_reg == 0) ? 1 : (bin_reg > MAX_BIN) ? MAX_BIN : int'(bin_reg);
    pos = chan_pos % MAX_CHANNELS;
    scan_end = chan_pos >= nch - 1;
    case (act)
      ACT_RESTART: clear_all();
      ACT_CAL: begin
        if (!frozen && cal_scans != {CNT_W{1'b1}}) begin
          cal_sum[pos] = cal_sum[pos] + CAL_W'(longint'(s));
          if (scan_end) begin
            cal_scans++;
            chan_pos = 0;
          end else begin
            chan_pos++;
          end
        end
      end
      ACT_MEAS: begin
        if (!frozen) begin
          freeze_means();
          pos = 0;
          scan_end = nch <= 1;
        end
        bin_end = scan_in_bin >= bin - 1;
        d = longint'(s) * 256 - mean_q8[pos];
        m = (d < 0) ? longint'(-d) : longint'(d);
        dev_sq_sum[pos] = dev_sq_sum[pos] + SQ_W'(m * m);
        if (bin_end) begin
          r = int_sqrt(longint'(dev_sq_sum[pos]) / bin);
          if (r > 64'hFFFFFF) r = 64'hFFFFFF;
          e.rms = RMS_W'(r);
          e.ch  = CH_W'(pos);
          rms_expected_q.push_back(e);
          dev_sq_sum[pos] = '0;
        end
        if (scan_end) begin
          chan_pos = 0;
          scan_in_bin = bin_end ? 0 : scan_in_bin + 1;
        end else begin
          chan_pos = pos + 1;
        end
      end
      default: ;  // unused action code: drop
    endcase
  endtask

  always @(posedge clk) begin
    rms_result_t e;
    if (rst) begin
      clear_all();
      nch_reg = NCH_REG_W'(1);
      bin_reg = BIN_REG_W'(10);
      rms_expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_NUM_CHANNELS) nch_reg = cfg.data[NCH_REG_W-1:0];
        else if (cfg.index == REG_BIN_SIZE) bin_reg = cfg.data[BIN_REG_W-1:0];
      end
      if (res.valid && res.ready) begin
        if (rms_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result rms=%0d ch=%0d", $realtime,
                     res.rms_value, res.channel_index);
        end else begin
          e = rms_expected_q.pop_front();
          if (e.rms !== res.rms_value || e.ch !== res.channel_index) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch: expected rms=%0d ch=%0d, got rms=%0d ch=%0d",
                       $realtime, e.rms, e.ch, res.rms_value, res.channel_index);
          end
        end
      end
      if (smp.valid && smp.ready) predict_sample(smp.action, smp.sample);
    end
    pending = rms_expected_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: top level for the binned RMS decimator
// Drives calibration/measurement sample streams over many channel and bin
// settings, with bursty input and a stalling result sink; the checker
// predicts every RMS result and reports mismatches.
// ---------------------------------------------------------------------------
module testbench;
  import brd_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int IDLE_WAIT    = 1200;   // covers the mean freeze pass
  localparam int HOLD_CYCLES  = 3000;

  logic clk = 0;
  logic rst = 1;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  bit   holdoff_req = 0;
  bit   holdoff_done = 0;
  int   hold_cnt = 0;
  int   sink_mode = 0;
  int   mode_left = 0;

  brd_sample_if samples ();
  brd_result_if results ();
  brd_cfg_if    cfg ();

  always #10 clk = ~clk;

  binned_rms_decimator DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  brd_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .smp     (samples),
    .res     (results),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result sink: changing stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    if (holdoff_req && !holdoff_done) begin
      results.ready <= 0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) holdoff_done = 1;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (sink_mode)
        0: results.ready <= 1;
        1: results.ready <= ($urandom_range(0, 1) == 1);
        2: results.ready <= ($urandom_range(0, 7) != 0);
        default: results.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  task automatic send_item(action_t act, logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        samples.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    samples.valid  <= 1;
    samples.action <= act;
    samples.sample <= s;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (act == ACT_CAL || act == ACT_MEAS) items_sent++;
  endtask

  task automatic settle();
    samples.valid <= 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= CFG_DAT_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int offset);
    case ($urandom_range(0, 5))
      0: return SAMPLE_W'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      2: return SAMPLE_W'(offset + int'($urandom_range(0, 400)) - 200);
      default: return SAMPLE_W'(offset + int'($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // one calibrate-then-measure run with random content
  task automatic run_phase(int nch_eff, int bin_eff, bit do_restart);
    int cal_scans;
    int meas_scans;
    int offset;
    if (do_restart) send_item(ACT_RESTART, SAMPLE_W'($urandom));
    offset = int'($urandom_range(0, 40000)) - 20000;
    cal_scans = $urandom_range(0, 6);
    meas_scans = bin_eff * $urandom_range(1, 3) + $urandom_range(0, bin_eff - 1);
    if (meas_scans * nch_eff > 150) meas_scans = 150 / nch_eff + 1;
    repeat (cal_scans * nch_eff) send_item(ACT_CAL, pick_sample(offset));
    for (int i = 0; i < meas_scans * nch_eff; i++) begin
      if ($urandom_range(0, 39) == 0)
        send_item(($urandom_range(0, 1) == 1) ? action_t'(2'd3) : ACT_CAL,
                  SAMPLE_W'($urandom));
      send_item(ACT_MEAS, pick_sample(offset));
    end
  endtask

  initial begin
    int nch_raw;
    int bin_raw;
    int nch_eff;
    int bin_eff;
    int phase_no;
    samples.valid  = 0;
    samples.action = ACT_CAL;
    samples.sample = '0;
    cfg.valid      = 0;
    cfg.index      = REG_NUM_CHANNELS;
    cfg.data       = '0;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset settings: no calibration, so the means freeze at zero
    send_item(action_t'(2'd3), 16'sh1234);
    for (int i = 0; i < 10; i++)
      send_item(ACT_MEAS, (i % 2 == 0) ? 16'sh8000 : 16'sh7FFF);
    send_item(ACT_CAL, 16'sh7FFF);  // ignored once frozen
    send_item(ACT_RESTART, 16'sh0000);
    settle();

    write_reg(REG_NUM_CHANNELS, 2);
    write_reg(REG_BIN_SIZE, 2);
    send_item(ACT_CAL, 16'sh8000);
    send_item(ACT_CAL, 16'sh7FFF);
    send_item(ACT_CAL, 16'sh8000);
    send_item(ACT_CAL, 16'sh7FFF);
    send_item(ACT_CAL, 16'sh0001);  // trailing half scan
    send_item(ACT_MEAS, 16'sh7FFF);
    send_item(ACT_MEAS, 16'sh8000);
    send_item(ACT_MEAS, 16'sh0000);
    send_item(ACT_MEAS, 16'shFFFF);
    send_item(ACT_MEAS, 16'sh5555);
    send_item(ACT_MEAS, 16'shAAAA);
    settle();

    // register extremes, including out-of-range values
    write_reg(REG_NUM_CHANNELS, 0);
    write_reg(REG_BIN_SIZE, 0);
    run_phase(1, 1, 1);
    settle();
    write_reg(REG_NUM_CHANNELS, 31);
    write_reg(REG_BIN_SIZE, 8191);
    run_phase(16, 1, 1);  // partial bin only: nothing comes out
    settle();
    write_reg(REG_NUM_CHANNELS, 16);
    write_reg(REG_BIN_SIZE, 4096);
    run_phase(16, 1, 1);
    settle();

    phase_no = 0;
    while (items_sent < 950) begin
      case ($urandom_range(0, 9))
        0: nch_raw = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(17, 31);
        1: nch_raw = 16;
        default: nch_raw = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: bin_raw = 0;
        1: bin_raw = $urandom_range(4097, 8191);
        default: bin_raw = $urandom_range(1, 6);
      endcase
      nch_eff = (nch_raw == 0) ? 1 : (nch_raw > 16) ? 16 : nch_raw;
      bin_eff = (bin_raw == 0) ? 1 : (bin_raw > 4096) ? 4096 : bin_raw;
      if (bin_eff > 8) bin_eff = 1;  // keep such phases short
      write_reg(REG_NUM_CHANNELS, nch_raw);
      write_reg(REG_BIN_SIZE, bin_raw);
      if (phase_no == 3) holdoff_req = 1;
      run_phase(nch_eff, bin_eff, $urandom_range(0, 5) != 0);
      settle();
      phase_no++;
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
